// ===== hdl/ptsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsm_pkg
// Shared types and constants for the prefix table string matcher.
// ----------------------------------------------------------------------------
package ptsm_pkg;

  localparam int TEXT_W         = 8;
  localparam int PAT_LEN_W      = 5;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int BYTES_PER_WORD = CFG_DATA_W / TEXT_W;
  localparam int START_W        = 16;

  localparam int DEF_MAX_PATTERN_BYTES = 16;
  localparam int DEF_POSITION_BITS     = 16;

  localparam logic [PAT_LEN_W-1:0] PAT_LEN_RESET = PAT_LEN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [TEXT_W-1:0] text_byte;
    logic              start_of_text;
  } in_item_t;

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
  } out_item_t;

  typedef struct packed {
    logic advance;
    logic restart;
    logic flush;
  } cell_ctrl_t;

endpackage

// ===== hdl/ptsm_cell.sv =====
// ----------------------------------------------------------------------------
// ptsm_cell
// One pattern position: holds whether the text ending at the last byte
// matches the pattern prefix through this position.
// ----------------------------------------------------------------------------
module ptsm_cell
  import ptsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic              seed,
  input  logic              prev_hit,
  input  logic [TEXT_W-1:0] pat_byte,
  input  logic [TEXT_W-1:0] text_byte,
  input  logic              is_last,
  output logic              hit_r,
  output logic              tap
);

  logic prev_eff;
  logic hit_nxt;

  assign prev_eff = seed | (prev_hit & ~ctrl.restart);
  assign hit_nxt  = prev_eff & (text_byte == pat_byte);
  assign tap      = hit_nxt & is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.flush) begin
      hit_r <= 1'b0;
    end else if (ctrl.advance) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

// ===== hdl/ptsm_cfg.sv =====
// ----------------------------------------------------------------------------
// ptsm_cfg
// Configuration registers, active pattern length and last-cell select.
// ----------------------------------------------------------------------------
module ptsm_cfg
  import ptsm_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
  parameter int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
)
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [CFG_IDX_W-1:0]         wr_index,
  input  logic [CFG_DATA_W-1:0]        wr_data,
  output logic [CFG_DATA_W-1:0]        pat_low,
  output logic [CFG_DATA_W-1:0]        pat_high,
  output logic [LEN_W-1:0]             len_m1,
  output logic [MAX_PATTERN_BYTES-1:0] last_sel,
  output logic                         flush
);

  logic [PAT_LEN_W-1:0]  length_r;
  logic [CFG_DATA_W-1:0] low_r;
  logic [CFG_DATA_W-1:0] high_r;
  logic [LEN_W-1:0]      len_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= PAT_LEN_RESET;
      low_r    <= '0;
      high_r   <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_PATTERN_LENGTH: length_r <= wr_data[PAT_LEN_W-1:0];
        REG_PATTERN_LOW:    low_r    <= wr_data;
        REG_PATTERN_HIGH:   high_r   <= wr_data;
        default:            ;
      endcase
    end
  end

  always_comb begin
    flush = 1'b0;
    if (wr_en) begin
      case (wr_index)
        REG_PATTERN_LENGTH,
        REG_PATTERN_LOW,
        REG_PATTERN_HIGH: flush = 1'b1;
        default:          flush = 1'b0;
      endcase
    end
  end

  always_comb begin
    if (length_r == '0) begin
      len_act = LEN_W'(1);
    end else if (int'(length_r) > MAX_PATTERN_BYTES) begin
      len_act = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_act = LEN_W'(length_r);
    end
  end

  assign len_m1   = len_act - LEN_W'(1);
  assign pat_low  = low_r;
  assign pat_high = high_r;

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_sel
    assign last_sel[i] = (len_m1 == LEN_W'(i));
  end

endmodule

// ===== hdl/prefix_table_string_matcher.sv =====
// ----------------------------------------------------------------------------
// prefix_table_string_matcher
// Streaming exact-pattern matcher over a chain of per-position cells.
//
//   channel | ports                          | dir | item
//   in      | in_valid in_ready in_item      | in  | text byte, restart flag
//   out     | out_valid out_ready out_item   | out | match flag, start pos
//   cfg     | cfg_valid cfg_ready cfg_index  | in  | register write
//           | cfg_data                       |     |
//
// One text byte per cycle while the result is not stalled. Each cell compares the byte with its pattern
// byte and passes its hit bit to the next cell; the result is registered
// and shows in the cycle after the item is taken.
// Reset (sync, rst_n low) loads length 1, zero pattern, clears position.
// A stalled result holds the output register; the next byte is taken in
// the cycle the result leaves. cfg_ready is always high.
// ----------------------------------------------------------------------------
module prefix_table_string_matcher
  import ptsm_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
  parameter int POSITION_BITS     = DEF_POSITION_BITS
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic                         in_fire;
  logic                         cfg_fire;
  logic [CFG_DATA_W-1:0]        pat_low;
  logic [CFG_DATA_W-1:0]        pat_high;
  logic [LEN_W-1:0]             len_m1;
  logic [MAX_PATTERN_BYTES-1:0] last_sel;
  logic                         flush;
  cell_ctrl_t                   ctrl;
  logic [MAX_PATTERN_BYTES-1:0] hit_vec;
  logic [MAX_PATTERN_BYTES-1:0] tap_vec;

  logic [POSITION_BITS-1:0]         text_pos_r;
  logic [POSITION_BITS-1:0]         pos_cur;
  logic [POSITION_BITS-1:0]         pos_nxt;
  logic [POSITION_BITS-1:0]         span;
  logic [POSITION_BITS-1:0]         start_full;
  logic [POSITION_BITS+START_W-1:0] start_ext;
  logic                             found;

  logic      out_valid_r;
  out_item_t out_item_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;

  ptsm_cfg #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .LEN_W             (LEN_W)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_fire),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .pat_low  (pat_low),
    .pat_high (pat_high),
    .len_m1   (len_m1),
    .last_sel (last_sel),
    .flush    (flush)
  );

  assign ctrl.advance = in_fire;
  assign ctrl.restart = in_item.start_of_text;
  assign ctrl.flush   = flush;

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
    logic [TEXT_W-1:0] pat_byte;
    logic              prev_hit;

    if (i < BYTES_PER_WORD) begin : g_low
      assign pat_byte = pat_low[TEXT_W*i +: TEXT_W];
    end else if (i < 2 * BYTES_PER_WORD) begin : g_high
      assign pat_byte = pat_high[TEXT_W*(i-BYTES_PER_WORD) +: TEXT_W];
    end else begin : g_zero
      assign pat_byte = '0;
    end

    if (i == 0) begin : g_head
      assign prev_hit = 1'b0;
    end else begin : g_link
      assign prev_hit = hit_vec[i-1];
    end

    ptsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .seed      ((i == 0) ? 1'b1 : 1'b0),
      .prev_hit  (prev_hit),
      .pat_byte  (pat_byte),
      .text_byte (in_item.text_byte),
      .is_last   (last_sel[i]),
      .hit_r     (hit_vec[i]),
      .tap       (tap_vec[i])
    );
  end

  assign found   = |tap_vec;
  assign pos_cur = in_item.start_of_text ? '0 : text_pos_r;
  assign pos_nxt = (pos_cur == POS_MAX) ? pos_cur : pos_cur + POSITION_BITS'(1);
  assign span    = POSITION_BITS'(len_m1);

  always_comb begin
    if (!found) begin
      start_full = '0;
    end else if (pos_cur >= span) begin
      start_full = pos_cur - span;
    end else begin
      start_full = '0;
    end
  end

  assign start_ext = {{START_W{1'b0}}, start_full};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_pos_r <= '0;
    end else if (in_fire) begin
      text_pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r.match_found <= found;
      out_item_r.match_start <= start_ext[START_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  a_flush_clears_chain: assert property (@(posedge clk) disable iff (!rst_n)
    flush |=> hit_vec == '0)
    else $error("hit chain not cleared after pattern write");

  a_restart_position: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_item.start_of_text |=> text_pos_r == POSITION_BITS'(1))
    else $error("position not restarted");

  a_no_match_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.match_found |-> out_item.match_start == '0)
    else $error("start position set without match");

  a_single_tap: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tap_vec))
    else $error("more than one last cell reports a match");

endmodule

// ===== tb/ptsm_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsm_match_checker
// Watches the text, result and register channels of the matcher. It keeps its
// own pattern, prefix table, matched length and text position, predicts the
// match result of every accepted text item and compares each accepted result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ptsm_match_checker
  import ptsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int MAX_B = DEF_MAX_PATTERN_BYTES;
  localparam int POS_W = DEF_POSITION_BITS;

  logic [PAT_LEN_W-1:0]  pat_len;
  logic [CFG_DATA_W-1:0] pat_lo;
  logic [CFG_DATA_W-1:0] pat_hi;
  logic [PAT_LEN_W-1:0]  prefix_tab [MAX_B];
  logic [PAT_LEN_W-1:0]  matched;
  logic [POS_W-1:0]      text_pos;
  out_item_t             expected_matches [$];
  int                    errors = 0;

  function automatic int active_len();
    int n;
    n = pat_len;
    if (n < 1) n = 1;
    if (n > MAX_B) n = MAX_B;
    return n;
  endfunction

  function automatic logic [TEXT_W-1:0] pat_byte(input int i);
    if (i < 8) return pat_lo[8*i +: 8];
    if (i < 16) return pat_hi[8*(i-8) +: 8];
    return '0;
  endfunction

  function automatic void build_prefix_table();
    int m;
    int k;
    int q;
    m = active_len();
    k = 0;
    foreach (prefix_tab[i]) prefix_tab[i] = '0;
    for (q = 1; q < m; q++) begin
      while (k > 0 && pat_byte(k) != pat_byte(q)) k = prefix_tab[k-1];
      if (pat_byte(k) == pat_byte(q)) k++;
      prefix_tab[q] = PAT_LEN_W'(k);
    end
    matched = '0;
  endfunction

  function automatic out_item_t predict_match(input in_item_t it);
    out_item_t        r;
    int               m;
    int               q;
    logic [POS_W-1:0] pos;
    r = '0;
    if (it.start_of_text) begin
      matched  = '0;
      text_pos = '0;
    end
    pos = text_pos;
    q   = matched;
    m   = active_len();
    if (q >= m) q = 0;
    while (q > 0 && pat_byte(q) != it.text_byte) q = prefix_tab[q-1];
    if (pat_byte(q) == it.text_byte) q++;
    if (q == m) begin
      r.match_found = 1'b1;
      r.match_start = (pos >= m - 1) ? START_W'(pos - (m - 1)) : '0;
      q = prefix_tab[m-1];
    end
    matched = PAT_LEN_W'(q);
    if (pos != '1) text_pos = pos + 1'b1;
    return r;
  endfunction

  task automatic report(input string field, input logic [START_W-1:0] want_v,
                        input logic [START_W-1:0] got_v);
    errors++;
    $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pat_len  = PAT_LEN_RESET;
      pat_lo   = '0;
      pat_hi   = '0;
      text_pos = '0;
      build_prefix_table();
      expected_matches.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: begin
            pat_len = cfg_data[PAT_LEN_W-1:0];
            build_prefix_table();
          end
          REG_PATTERN_LOW: begin
            pat_lo = cfg_data;
            build_prefix_table();
          end
          REG_PATTERN_HIGH: begin
            pat_hi = cfg_data;
            build_prefix_table();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_matches = {expected_matches, predict_match(in_item)};
      if (out_valid && out_ready) begin
        if (expected_matches.size() == 0) begin
          errors++;
          $error("result item with nothing expected");
        end else begin
          want = expected_matches.pop_front();
          if (out_item.match_found !== want.match_found)
            report("match_found", want.match_found, out_item.match_found);
          if (out_item.match_start !== want.match_start)
            report("match_start", want.match_start, out_item.match_start);
        end
      end
    end
    pending    <= expected_matches.size();
    fail_count <= errors;
  end

endmodule

// ===== tb/prefix_table_string_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_table_string_matcher_tb
// Drives text bytes and register writes into the matcher: directed patterns
// for overlap, fallback, length clamping and the unused register index, then
// random patterns with embedded, broken and noise text. Both sides idle at
// random. Prediction and checking live in ptsm_match_checker.
// ----------------------------------------------------------------------------
module prefix_table_string_matcher_tb;
  import ptsm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 20;
  localparam int PHASE_ITEMS = 45;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    stall_cycles = 0;
  int                    tx_mode = 1;
  int                    rx_mode = 1;
  logic [127:0]          cur_pat;
  int                    cur_len;

  prefix_table_string_matcher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ptsm_match_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // 0: never idle, 1: uniform gaps, 2: mostly back to back
  function automatic int gap_for(input int mode);
    if (mode == 1) return $urandom_range(0, 12);
    if (mode == 2) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
    return 0;
  endfunction

  function automatic logic [127:0] pack_str(input string s);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < s.len(); i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  task automatic push_byte(input logic [TEXT_W-1:0] b, input logic sot);
    int       gap;
    in_item_t it;
    gap = gap_for(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.text_byte     = b;
    it.start_of_text = sot;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_str(input string s, input logic sot_first);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], sot_first && i == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_pattern(input logic [PAT_LEN_W-1:0] code, input logic [127:0] bytes);
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[PAT_LEN_W-1:0] = code;
    drain();
    if ($urandom_range(0, 1)) write_reg(REG_PATTERN_LENGTH, len_word);
    write_reg(REG_PATTERN_LOW, bytes[63:0]);
    write_reg(REG_PATTERN_HIGH, bytes[127:64]);
    write_reg(REG_PATTERN_LENGTH, len_word);
    cfg_valid <= 1'b0;
    cur_pat = bytes;
    cur_len = (code == 0) ? 1 : (code > 16) ? 16 : code;
  endtask

  task automatic random_phase(input int n_items, input logic [PAT_LEN_W-1:0] code);
    logic [TEXT_W-1:0] alpha [3];
    logic [127:0]      pat;
    logic [TEXT_W-1:0] b;
    int                asz;
    int                sent;
    int                act;
    int                k;
    asz = $urandom_range(1, 3);
    foreach (alpha[i]) alpha[i] = $urandom_range(0, 255);
    for (int i = 0; i < 16; i++) pat[8*i +: 8] = alpha[$urandom_range(0, asz - 1)];
    tx_mode = $urandom_range(0, 2);
    rx_mode = $urandom_range(0, 2);
    load_pattern(code, pat);
    sent = 0;
    while (sent < n_items) begin
      act = $urandom_range(0, 7);
      if (act < 4) k = cur_len;
      else if (act < 6) k = $urandom_range(1, cur_len);
      else k = 0;
      if (k == 0) begin
        b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                        : alpha[$urandom_range(0, asz - 1)];
        push_byte(b, $urandom_range(0, 47) == 0);
        sent++;
      end else begin
        for (int j = 0; j < k; j++) begin
          push_byte(cur_pat[8*j +: 8], $urandom_range(0, 47) == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [PAT_LEN_W-1:0] code;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pattern: one zero byte
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);

    // fallback through the prefix table
    load_pattern(5'd4, pack_str("abab"));
    send_str("ababab", 1'b1);

    // overlapping matches
    load_pattern(5'd3, pack_str("aaa"));
    send_str("aaaa", 1'b1);

    // unused index keeps the partial match, a real write drops it
    drain();
    write_reg(REG_SPARE, '1);
    cfg_valid <= 1'b0;
    push_byte("a", 1'b0);
    drain();
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(3));
    cfg_valid <= 1'b0;
    push_byte("a", 1'b0);

    // zero length acts as one
    load_pattern(5'd0, {{15{8'h5A}}, 8'hFF});
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFE, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: code = 5'd1;
        1: code = 5'd16;
        2: code = 5'd0;
        3: code = 5'd31;
        4: code = 5'd17;
        default: begin
          if ($urandom_range(0, 4) == 0) code = PAT_LEN_W'($urandom_range(0, 31));
          else if ($urandom_range(0, 1)) code = PAT_LEN_W'($urandom_range(1, 6));
          else code = PAT_LEN_W'($urandom_range(1, 16));
        end
      endcase
      random_phase(PHASE_ITEMS, code);
    end

    random_phase(PHASE_ITEMS, PAT_LEN_W'($urandom_range(1, 8)));

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS prefix_table_string_matcher");
    end else begin
      $display("FAIL prefix_table_string_matcher");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = gap_for(rx_mode);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL prefix_table_string_matcher");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
